// ===== hw/rtl/multi_sensor_echo_ranger_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the echo ranger core
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTI_SENSOR_ECHO_RANGER_CORE_MACROS_SVH
`define MULTI_SENSOR_ECHO_RANGER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define MSER_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define MSER_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MSER_ASSERT_IMP(label, ante, cons)
`define MSER_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/mser_pkg.sv =====
// ----------------------------------------------------------------------------
// Echo ranger package
// Sizes, register map and reset values shared by the echo ranger core.
// ----------------------------------------------------------------------------
`default_nettype none

package mser_pkg;

  localparam int MAX_SENSORS  = 16;
  localparam int SENSOR_W     = $clog2(MAX_SENSORS);
  localparam int COUNT_WIDTH  = 16;
  localparam int SCOUNT_W     = 5;
  localparam int TRIG_W       = 8;
  localparam int RANGE_W      = 16;
  localparam int ADDR_W       = 4;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 24;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_SENSOR_COUNT  = 2'd0,
    REG_CYCLE_TICKS   = 2'd1,
    REG_MAX_TICKS     = 2'd2,
    REG_TRIGGER_TICKS = 2'd3
  } reg_idx_t;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  localparam logic [SCOUNT_W-1:0]    RST_SENSOR_COUNT  = '0;
  localparam logic [COUNT_WIDTH-1:0] RST_CYCLE_TICKS   = COUNT_WIDTH'(12500);
  localparam logic [COUNT_WIDTH-1:0] RST_MAX_TICKS     = COUNT_WIDTH'(2915);
  localparam logic [TRIG_W-1:0]      RST_TRIGGER_TICKS = TRIG_W'(3);

  // One result transaction.
  typedef struct packed {
    logic                   done;
    logic [RANGE_W-1:0]     range_value;
    logic [SENSOR_W-1:0]    trigger_sensor;
    logic                   trigger_active;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/multi_sensor_echo_ranger_core.sv =====
// ----------------------------------------------------------------------------
// Multi-sensor echo ranger core
// Round-robin ultrasonic trigger and echo pulse-width measurement.
// ----------------------------------------------------------------------------
// Each tick transaction advances a 16-bit wrapping counter and samples the
// shared echo line; a read transaction returns the stored range of one sensor.
// Every transaction is processed combinationally between the input handshake
// and a result register, so one transaction is accepted per clock cycle while
// the skid register is empty; the skid register behind the result register
// keeps input accepted for one more transaction while the result side stalls.
// The range store clears at reset with no start-up pass. Configuration
// registers may be written only while no results are outstanding.
`default_nettype none
`include "multi_sensor_echo_ranger_core_macros.svh"

module multi_sensor_echo_ranger_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input stream
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [mser_pkg::IN_TDATA_W-1:0]       in_tdata,   // echo_level, read_index
  input  wire logic                                  in_tuser,   // action
  // result stream
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [mser_pkg::OUT_TDATA_W-1:0]           out_tdata,  // trigger_active,
                                                                 // trigger_sensor, range_value
  output logic                                       out_tuser,  // measurement_done
  // configuration
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [mser_pkg::ADDR_W-1:0]           paddr,
  input  wire logic [31:0]                           pwdata,
  output logic [31:0]                                prdata,
  output logic                                       pready
);

  localparam int SW = mser_pkg::SENSOR_W;
  localparam int CW = mser_pkg::COUNT_WIDTH;
  localparam int RW = mser_pkg::RANGE_W;
  localparam int TW = mser_pkg::TRIG_W;
  localparam int NW = mser_pkg::SCOUNT_W;

  // Configuration registers
  logic [NW-1:0] sensor_count_r;
  logic [CW-1:0] cycle_ticks_r;
  logic [CW-1:0] max_ticks_r;
  logic [TW-1:0] trigger_ticks_r;
  logic          cfg_wr;
  mser_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = mser_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_count_r  <= mser_pkg::RST_SENSOR_COUNT;
      cycle_ticks_r   <= mser_pkg::RST_CYCLE_TICKS;
      max_ticks_r     <= mser_pkg::RST_MAX_TICKS;
      trigger_ticks_r <= mser_pkg::RST_TRIGGER_TICKS;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mser_pkg::REG_SENSOR_COUNT:  sensor_count_r  <= pwdata[NW-1:0];
        mser_pkg::REG_CYCLE_TICKS:   cycle_ticks_r   <= pwdata[CW-1:0];
        mser_pkg::REG_MAX_TICKS:     max_ticks_r     <= pwdata[CW-1:0];
        mser_pkg::REG_TRIGGER_TICKS: trigger_ticks_r <= pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mser_pkg::REG_SENSOR_COUNT:  prdata = 32'(sensor_count_r);
      mser_pkg::REG_CYCLE_TICKS:   prdata = 32'(cycle_ticks_r);
      mser_pkg::REG_MAX_TICKS:     prdata = 32'(max_ticks_r);
      mser_pkg::REG_TRIGGER_TICKS: prdata = 32'(trigger_ticks_r);
      default:                     prdata = '0;
    endcase
  end

  // Measurement state
  logic [CW-1:0] cnt_r,    cnt_nxt;
  logic [SW-1:0] sensor_r, sensor_nxt;
  logic          started_r, started_nxt;
  logic          awaiting_r, awaiting_nxt;
  logic          prev_echo_r, prev_echo_nxt;
  logic [CW-1:0] rise_r,   rise_nxt;
  logic [TW-1:0] pulse_r,  pulse_nxt;

  logic [RW-1:0]          store_r [mser_pkg::MAX_SENSORS];
  logic [mser_pkg::MAX_SENSORS-1:0] store_vld_r;

  // Input fields
  logic               accept;
  logic               is_tick;
  logic               echo;
  logic [SW-1:0]      rd_idx;

  // Per-tick logic
  logic [CW-1:0] cnt_inc;
  logic          rise_ev;
  logic          fall_ev;
  logic [CW-1:0] width;
  logic [RW-1:0] stored;
  logic [NW-1:0] count_sat;
  logic [NW-1:0] sensor_inc;
  logic          trig_fire;
  logic          store_we;
  mser_pkg::result_t res;

  assign accept  = in_tvalid && in_tready;
  assign is_tick = (mser_pkg::action_t'(in_tuser) == mser_pkg::ACT_TICK);
  assign echo    = in_tdata[0];
  assign rd_idx  = in_tdata[SW:1];

  assign cnt_inc   = cnt_r + CW'(1);
  assign rise_ev   = started_r && echo && !prev_echo_r && awaiting_r;
  assign fall_ev   = started_r && !echo && prev_echo_r && !awaiting_r;
  assign width     = cnt_inc - rise_r;
  assign stored    = (width <= max_ticks_r) ? RW'(width) : '0;
  assign count_sat = (sensor_count_r > NW'(mser_pkg::MAX_SENSORS)) ?
                     NW'(mser_pkg::MAX_SENSORS) : sensor_count_r;
  assign sensor_inc = NW'(sensor_r) + NW'(1);
  assign trig_fire = is_tick && (count_sat != '0) && (cnt_inc > cycle_ticks_r);
  assign store_we  = accept && is_tick && fall_ev;

  always_comb begin
    cnt_nxt       = cnt_r;
    sensor_nxt    = sensor_r;
    started_nxt   = started_r;
    awaiting_nxt  = awaiting_r;
    prev_echo_nxt = prev_echo_r;
    rise_nxt      = rise_r;
    pulse_nxt     = pulse_r;
    res.done        = 1'b0;
    res.range_value = '0;

    if (!is_tick) begin
      if (store_vld_r[rd_idx]) begin
        res.range_value = store_r[rd_idx];
      end
    end else begin
      cnt_nxt = cnt_inc;
      if (rise_ev) begin
        rise_nxt     = cnt_inc;
        awaiting_nxt = 1'b0;
      end else if (fall_ev) begin
        awaiting_nxt    = 1'b1;
        res.done        = 1'b1;
        res.range_value = stored;
      end
      prev_echo_nxt = echo;
      if (pulse_r != '0) begin
        pulse_nxt = pulse_r - TW'(1);
      end
      if (trig_fire) begin
        // The first trigger and a sensor past a lowered count both restart at 0.
        if (!started_r || sensor_inc >= count_sat) begin
          sensor_nxt = '0;
        end else begin
          sensor_nxt = sensor_inc[SW-1:0];
        end
        started_nxt = 1'b1;
        cnt_nxt     = '0;
        pulse_nxt   = (trigger_ticks_r != '0) ? trigger_ticks_r : TW'(1);
      end
    end

    res.trigger_active = (pulse_nxt != '0);
    res.trigger_sensor = sensor_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sensor_r    <= '0;
      started_r   <= 1'b0;
      awaiting_r  <= 1'b1;
      prev_echo_r <= 1'b0;
      rise_r      <= '0;
      pulse_r     <= '0;
    end else if (accept) begin
      cnt_r       <= cnt_nxt;
      sensor_r    <= sensor_nxt;
      started_r   <= started_nxt;
      awaiting_r  <= awaiting_nxt;
      prev_echo_r <= prev_echo_nxt;
      rise_r      <= rise_nxt;
      pulse_r     <= pulse_nxt;
    end
  end

  // Range store: an entry without its valid bit reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_vld_r <= '0;
    end else if (store_we) begin
      store_vld_r[sensor_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[sensor_r] <= stored;
    end
  end

  // Result register with a skid register behind it
  logic              out_vld_r;
  logic              skid_vld_r;
  mser_pkg::result_t out_r;
  mser_pkg::result_t skid_r;
  logic              pop;

  assign in_tready = !skid_vld_r;
  assign pop       = out_vld_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (accept) begin
      if (out_vld_r && !pop) begin
        skid_vld_r <= 1'b1;
      end else begin
        out_vld_r <= 1'b1;
      end
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (accept) begin
      if (out_vld_r && !pop) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_r.done;
  assign out_tdata  = mser_pkg::OUT_TDATA_W'({out_r.range_value, out_r.trigger_sensor,
                                              out_r.trigger_active});

  // Checks
  `MSER_ASSERT_IMP(a_skid_behind_out, skid_vld_r, out_vld_r)
  `MSER_ASSERT_NXT(a_trigger_starts_pulse, accept && trig_fire,
                   pulse_r != '0 && cnt_r == '0 && started_r)
  `MSER_ASSERT_NXT(a_fall_rearms, store_we, awaiting_r && out_vld_r)

endmodule

`default_nettype wire

// ===== tb/sv/multi_sensor_echo_ranger_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Echo ranger result checker
// Follows register writes and input transactions, works out the reading that
// each input transaction should give, and compares every result transaction
// field by field with the oldest outstanding reading.
// ----------------------------------------------------------------------------

module multi_sensor_echo_ranger_checker
  import mser_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // echo_level, read_index
  input  logic                   in_tuser,   // action
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // trigger_active, trigger_sensor, range_value
  input  logic                   out_tuser,  // measurement_done
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [31:0]            pwdata,
  input  logic                   pready,
  output int                     failures,
  output int                     pending
);

  typedef struct {
    logic                active;
    logic [SENSOR_W-1:0] sensor;
    logic                done;
    logic [RANGE_W-1:0]  range_val;
  } reading_t;

  // Register copies.
  logic [SCOUNT_W-1:0]    sensor_count_q;
  logic [COUNT_WIDTH-1:0] cycle_ticks_q;
  logic [COUNT_WIDTH-1:0] max_ticks_q;
  logic [TRIG_W-1:0]      trigger_ticks_q;

  // Ranging state.
  logic [COUNT_WIDTH-1:0] tick_count;
  logic [COUNT_WIDTH-1:0] rise_stamp;
  logic [SENSOR_W-1:0]    sensor_sel;
  logic                   armed;
  logic                   want_rise;
  logic                   echo_prev;
  logic [TRIG_W-1:0]      pulse_left;
  logic [RANGE_W-1:0]     range_mem [MAX_SENSORS];

  reading_t expected_readings [$];
  int       fail_count = 0;

  assign failures = fail_count;

  function automatic void reset_ranger();
    sensor_count_q  = RST_SENSOR_COUNT;
    cycle_ticks_q   = RST_CYCLE_TICKS;
    max_ticks_q     = RST_MAX_TICKS;
    trigger_ticks_q = RST_TRIGGER_TICKS;
    tick_count      = '0;
    rise_stamp      = '0;
    sensor_sel      = '0;
    armed           = 1'b0;
    want_rise       = 1'b1;
    echo_prev       = 1'b0;
    pulse_left      = '0;
    for (int i = 0; i < MAX_SENSORS; i++) range_mem[i] = '0;
  endfunction

  function automatic reading_t predict_reading(action_t act, logic echo,
                                               logic [SENSOR_W-1:0] idx);
    reading_t               r;
    logic [COUNT_WIDTH-1:0] width;
    logic [RANGE_W-1:0]     kept;
    int                     live;
    r.done      = 1'b0;
    r.range_val = '0;
    if (act == ACT_READ) begin
      r.range_val = range_mem[idx];
    end else begin
      tick_count = tick_count + 1'b1;
      // Edges count only once a sensor has been triggered.
      if (armed) begin
        if (echo && !echo_prev && want_rise) begin
          rise_stamp = tick_count;
          want_rise  = 1'b0;
        end else if (!echo && echo_prev && !want_rise) begin
          width = tick_count - rise_stamp;
          kept  = (width <= max_ticks_q) ? width : '0;
          range_mem[sensor_sel] = kept;
          want_rise   = 1'b1;
          r.done      = 1'b1;
          r.range_val = kept;
        end
      end
      echo_prev = echo;
      if (pulse_left != 0) pulse_left = pulse_left - 1'b1;
      live = (sensor_count_q > MAX_SENSORS) ? MAX_SENSORS : int'(sensor_count_q);
      if (live != 0 && tick_count > cycle_ticks_q) begin
        if (!armed || int'(sensor_sel) + 1 >= live) sensor_sel = '0;
        else sensor_sel = sensor_sel + 1'b1;
        armed      = 1'b1;
        tick_count = '0;
        pulse_left = (trigger_ticks_q != 0) ? trigger_ticks_q : TRIG_W'(1);
      end
    end
    r.active = (pulse_left != 0);
    r.sensor = sensor_sel;
    return r;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    reading_t want;
    if (!rst_n) begin
      reset_ranger();
      expected_readings.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_SENSOR_COUNT:  sensor_count_q  = pwdata[SCOUNT_W-1:0];
          REG_CYCLE_TICKS:   cycle_ticks_q   = pwdata[COUNT_WIDTH-1:0];
          REG_MAX_TICKS:     max_ticks_q     = pwdata[COUNT_WIDTH-1:0];
          REG_TRIGGER_TICKS: trigger_ticks_q = pwdata[TRIG_W-1:0];
          default: ;
        endcase
      end
      // The result side is handled first: a result leaving at this edge
      // belongs to an input transaction accepted at an earlier edge.
      if (out_tvalid && out_tready) begin
        if (expected_readings.size() == 0) begin
          $error("result transaction with no reading outstanding: tdata 0x%0h", out_tdata);
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          compare_field("trigger_active", want.active, out_tdata[0]);
          compare_field("trigger_sensor", want.sensor, out_tdata[SENSOR_W:1]);
          compare_field("range_value", want.range_val,
                        out_tdata[SENSOR_W+RANGE_W:SENSOR_W+1]);
          compare_field("measurement_done", want.done, out_tuser);
          compare_field("tdata padding", 0, out_tdata[OUT_TDATA_W-1:SENSOR_W+RANGE_W+1]);
        end
      end
      if (in_tvalid && in_tready)
        expected_readings.push_back(predict_reading(action_t'(in_tuser), in_tdata[0],
                                                    in_tdata[SENSOR_W:1]));
    end
    pending <= expected_readings.size();
  end

endmodule

// ===== tb/sv/multi_sensor_echo_ranger_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Echo ranger core testbench
// Drives tick and read transactions with echo pulse trains of random widths
// through a series of register settings, with bursty input and a stalling
// result side; the checker beside the core predicts and compares results.
// ----------------------------------------------------------------------------

module multi_sensor_echo_ranger_core_tb;
  import mser_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1450;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // echo_level, read_index
  logic                   in_tuser   = 1'b0; // action
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // trigger_active, trigger_sensor, range_value
  logic                   out_tuser;         // measurement_done
  logic                   psel       = 1'b0;
  logic                   penable    = 1'b0;
  logic                   pwrite     = 1'b0;
  logic [ADDR_W-1:0]      paddr      = '0;
  logic [31:0]            pwdata     = '0;
  logic [31:0]            prdata;
  logic                   pready;

  int   failures;
  int   pending;
  int   burst_left  = 0;
  int   items_sent  = 0;
  int   quiet_count = 0;
  int   stall_mode  = 0;
  int   stall_span  = 0;
  int   stall_phase = 0;
  logic echo_line   = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_sensor_echo_ranger_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  multi_sensor_echo_ranger_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .failures   (failures),
    .pending    (pending)
  );

  // The result side switches between free flow, light, periodic and heavy stalls.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(16, 160);
    end else begin
      stall_span <= stall_span - 1;
    end
    stall_phase <= (stall_phase + 1) % 7;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 2) != 0);
      2:       out_tready <= (stall_phase >= 3);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (psel && penable && pready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  task automatic send_item(input action_t act, input logic echo,
                           input logic [SENSOR_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(IN_TDATA_W-SENSOR_W-1){1'b0}}, idx, echo};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_ticks(input logic [15:0] levels, input int count);
    for (int i = 0; i < count; i++)
      send_item(ACT_TICK, levels[i], SENSOR_W'($urandom_range(0, MAX_SENSORS - 1)));
  endtask

  // Stops input and waits until every predicted reading has been returned.
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_ranger(input int count, input int cycle, input int longest,
                            input int pulse);
    write_reg(REG_SENSOR_COUNT, count);
    write_reg(REG_CYCLE_TICKS, cycle);
    write_reg(REG_MAX_TICKS, longest);
    write_reg(REG_TRIGGER_TICKS, pulse);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_settings();
    int count;
    int cycle;
    int longest;
    int pulse;
    case ($urandom_range(0, 9))
      0:       count = 0;
      1:       count = 16;
      2:       count = $urandom_range(17, 31);
      3:       count = 1;
      default: count = $urandom_range(2, 16);
    endcase
    case ($urandom_range(0, 9))
      0:       cycle = 0;
      1:       cycle = 65535;
      2:       cycle = $urandom_range(0, 65535);
      default: cycle = $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 9))
      0:       longest = 0;
      1:       longest = 65535;
      2:       longest = $urandom_range(0, 65535);
      default: longest = $urandom_range(1, 30);
    endcase
    case ($urandom_range(0, 9))
      0:       pulse = 0;
      1:       pulse = 1;
      2:       pulse = 255;
      3:       pulse = $urandom_range(0, 255);
      default: pulse = $urandom_range(1, 12);
    endcase
    set_ranger(count, cycle, longest, pulse);
  endtask

  // Echo pulse trains of random widths, with reads and stray samples mixed in.
  // The line level carries over between phases, so a pulse may straddle a
  // change of settings.
  task automatic run_echo_phase(input int count);
    int run_left;
    int pick;
    run_left = $urandom_range(0, 6);
    repeat (count) begin
      pick = $urandom_range(0, 15);
      if (pick < 2) begin
        send_item(ACT_READ, 1'($urandom_range(0, 1)),
                  SENSOR_W'($urandom_range(0, MAX_SENSORS - 1)));
      end else if (pick == 2) begin
        send_item(ACT_TICK, 1'($urandom_range(0, 1)),
                  SENSOR_W'($urandom_range(0, MAX_SENSORS - 1)));
      end else begin
        if (run_left == 0) begin
          echo_line = !echo_line;
          if (!echo_line)
            run_left = $urandom_range(1, 20);
          else if ($urandom_range(0, 5) == 0)
            run_left = $urandom_range(30, 150);
          else
            run_left = $urandom_range(1, 25);
        end
        send_item(ACT_TICK, echo_line, SENSOR_W'($urandom_range(0, MAX_SENSORS - 1)));
        run_left--;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Ranges read back as zero after reset.
    send_item(ACT_READ, 1'b0, '0);
    send_item(ACT_READ, 1'b1, SENSOR_W'(MAX_SENSORS - 1));
    // No sensor triggered yet, so these edges must be ignored.
    send_ticks(16'b0101, 4);

    // Oversized count, a trigger on every tick and a zero pulse length.
    drain();
    set_ranger(31, 0, 65535, 0);
    send_ticks(16'b00110, 5);

    // Widest pulse length, and every width exceeding a zero limit.
    drain();
    set_ranger(16, 2, 0, 255);
    send_ticks(16'b0111, 4);
    send_item(ACT_READ, 1'b0, SENSOR_W'(1));
    send_item(ACT_READ, 1'b1, SENSOR_W'(2));

    // Count lowered below the selected sensor; then a pulse left open while
    // triggering is switched off must still complete.
    drain();
    set_ranger(2, 3, 65535, 1);
    send_ticks(16'b1100, 4);
    drain();
    set_ranger(0, 3, 65535, 1);
    send_ticks(16'b0, 1);
    send_item(ACT_READ, 1'b0, SENSOR_W'(0));

    echo_line = 1'b0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      drain();
      random_settings();
      run_echo_phase($urandom_range(30, 120));
    end

    drain();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mser_pkg.sv
hw/rtl/multi_sensor_echo_ranger_core.sv
tb/sv/multi_sensor_echo_ranger_checker.sv
tb/sv/multi_sensor_echo_ranger_core_tb.sv
